// File: design/dpwp_pkg.sv
package dpwp_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_INV_FOCAL_X = 3'd0;
    localparam logic [2:0] REG_INV_FOCAL_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_X    = 3'd2;
    localparam logic [2:0] REG_CENTER_Y    = 3'd3;
    localparam logic [2:0] REG_POSE_ROW_X  = 3'd4;
    localparam logic [2:0] REG_POSE_ROW_Y  = 3'd5;
    localparam logic [2:0] REG_POSE_ROW_Z  = 3'd6;

    // reset values
    localparam logic [23:0] RST_INV_FOCAL = 24'd33554;
    localparam logic [15:0] RST_CENTER_X  = 16'd5120;
    localparam logic [15:0] RST_CENTER_Y  = 16'd3840;
    localparam logic [63:0] RST_POSE_X    = 64'd16384;
    localparam logic [63:0] RST_POSE_Y    = 64'd1073741824;
    localparam logic [63:0] RST_POSE_Z    = 64'd70368744177664;

    // kept pixel passed from front to back
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [15:0] depth;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } pix_t;

    // configuration seen by the back part
    typedef struct packed {
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [63:0] pose_x;
        logic [63:0] pose_y;
        logic [63:0] pose_z;
    } cfg_t;

    // world point with colour
    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [31:0] wz;
        logic signed [31:0] wy;
        logic signed [31:0] wx;
    } pt_t;

endpackage

// File: design/dpwp_front.sv
module dpwp_front #(
    parameter int STEP       = 3,
    parameter int MIN_DEPTH  = 10,
    parameter int COORD_BITS = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  dpwp_pkg::pix_t  in_pix,
    output logic            in_ready,
    output logic            q_valid,
    output dpwp_pkg::pix_t  q_pix,
    input  logic            q_ready
);

    localparam int SDIV = (STEP < 1) ? 1 : STEP;
    localparam logic [11:0] CMASK = 12'((1 << COORD_BITS) - 1);
    // reciprocal of the step, exact floor for every 12-bit coordinate
    localparam int RSH = 17;
    localparam logic [17:0] RECIP = 18'(((1 << RSH) + SDIV - 1) / SDIV);

    // two-entry queue
    dpwp_pkg::pix_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    logic [11:0] row_m, col_m;
    logic [29:0] row_p, col_p;
    logic [11:0] row_q, col_q;
    logic        keep, push, pop;

    // grid and depth test, the quotient comes from a reciprocal multiply
    always_comb
    begin
        row_m = in_pix.row & CMASK;
        col_m = in_pix.col & CMASK;
        row_p = 30'(row_m) * 30'(RECIP);
        col_p = 30'(col_m) * 30'(RECIP);
        row_q = row_p[RSH +: 12];
        col_q = col_p[RSH +: 12];
        keep  = ((row_q * 12'(SDIV)) == row_m) && ((col_q * 12'(SDIV)) == col_m)
              && (in_pix.depth != 16'd0) && ({16'd0, in_pix.depth} >= 32'(MIN_DEPTH));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_pix    = mem_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{row: row_m, col: col_m, depth: in_pix.depth,
                                 blue: in_pix.blue, green: in_pix.green, red: in_pix.red};
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: design/dpwp_back.sv
module dpwp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  dpwp_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  dpwp_pkg::pix_t  q_pix,
    output logic            q_ready,
    output logic            o_valid,
    output dpwp_pkg::pt_t   o_pt,
    input  logic            o_ready
);

    // five-stage pipeline with a global stall and an output register
    logic [4:0] v_reg;
    logic       adv;

    // stage 1: offsets and depth
    logic signed [17:0] dx1_reg, dy1_reg;
    logic [15:0]        d1_reg;
    logic [23:0]        c1_reg;
    // stage 2: offset times depth
    logic signed [34:0] px2_reg, py2_reg;
    logic [15:0]        d2_reg;
    logic [23:0]        c2_reg;
    // stage 3: times reciprocal focal; stage 4: rounded to q.8
    logic signed [59:0] fx3_reg, fy3_reg;
    logic [15:0]        d3_reg;
    logic [23:0]        c3_reg;
    logic signed [39:0] xq4_reg, yq4_reg, zq4_reg;
    logic [23:0]        c4_reg;
    // stage 5: rotation products
    logic signed [55:0] m5_reg [3][3];
    logic [23:0]        c5_reg;

    dpwp_pkg::pt_t out_reg;
    logic          out_v_reg;

    assign adv     = !out_v_reg || o_ready;
    assign q_ready = adv;
    assign o_valid = out_v_reg;
    assign o_pt    = out_reg;

    logic [63:0] pose [3];
    assign pose[0] = cfg.pose_x;
    assign pose[1] = cfg.pose_y;
    assign pose[2] = cfg.pose_z;

    logic signed [39:0] rnd_x, rnd_y;
    assign rnd_x = 40'((fx3_reg + 60'sd524288) >>> 20);
    assign rnd_y = 40'((fy3_reg + 60'sd524288) >>> 20);

    // final sum, round and saturate
    logic signed [58:0] acc [3];
    logic signed [36:0] wr  [3];
    logic signed [31:0] ws  [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = 59'(m5_reg[i][0]) + 59'(m5_reg[i][1]) + 59'(m5_reg[i][2])
                   + 59'({{43{pose[i][63]}}, pose[i][63:48]} <<< 22)
                   + 59'sd2097152;
            wr[i]  = 37'(acc[i] >>> 22);
            if (wr[i] > 37'sd2147483647)
            begin
                ws[i] = 32'sh7fffffff;
            end
            else if (wr[i] < -37'sd2147483648)
            begin
                ws[i] = 32'sh80000000;
            end
            else
            begin
                ws[i] = 32'(wr[i]);
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg <= $signed({2'b0, q_pix.col, 4'b0}) - $signed({2'b0, cfg.center_x});
            dy1_reg <= $signed({2'b0, q_pix.row, 4'b0}) - $signed({2'b0, cfg.center_y});
            d1_reg  <= q_pix.depth;
            c1_reg  <= {q_pix.red, q_pix.green, q_pix.blue};
            px2_reg <= 35'(dx1_reg * $signed({1'b0, d1_reg}));
            py2_reg <= 35'(dy1_reg * $signed({1'b0, d1_reg}));
            d2_reg  <= d1_reg;
            c2_reg  <= c1_reg;
            fx3_reg <= 60'(px2_reg * $signed({1'b0, cfg.inv_focal_x}));
            fy3_reg <= 60'(py2_reg * $signed({1'b0, cfg.inv_focal_y}));
            d3_reg  <= d2_reg;
            c3_reg  <= c2_reg;
            xq4_reg <= rnd_x;
            yq4_reg <= rnd_y;
            zq4_reg <= $signed({16'd0, d3_reg, 8'd0});
            c4_reg  <= c3_reg;
            for (int i = 0; i < 3; i++)
            begin
                m5_reg[i][0] <= 56'($signed(pose[i][15:0])  * xq4_reg);
                m5_reg[i][1] <= 56'($signed(pose[i][31:16]) * yq4_reg);
                m5_reg[i][2] <= 56'($signed(pose[i][47:32]) * zq4_reg);
            end
            c5_reg  <= c4_reg;
            out_reg <= '{red: c5_reg[23:16], green: c5_reg[15:8], blue: c5_reg[7:0],
                         wz: ws[2], wy: ws[1], wx: ws[0]};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg     <= {v_reg[3:0], q_valid};
            out_v_reg <= v_reg[4];
        end
    end

endmodule

// File: design/dpwp_regs.sv
module dpwp_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [5:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output dpwp_pkg::cfg_t  cfg
);

    dpwp_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr;

    assign idx  = paddr[5:3];
    assign wr   = psel && penable && pwrite;
    assign cfg  = cfg_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{inv_focal_x: dpwp_pkg::RST_INV_FOCAL,
                         inv_focal_y: dpwp_pkg::RST_INV_FOCAL,
                         center_x: dpwp_pkg::RST_CENTER_X, center_y: dpwp_pkg::RST_CENTER_Y,
                         pose_x: dpwp_pkg::RST_POSE_X, pose_y: dpwp_pkg::RST_POSE_Y,
                         pose_z: dpwp_pkg::RST_POSE_Z};
        end
        else if (wr)
        begin
            unique case (idx)
                dpwp_pkg::REG_INV_FOCAL_X: cfg_reg.inv_focal_x <= pwdata[23:0];
                dpwp_pkg::REG_INV_FOCAL_Y: cfg_reg.inv_focal_y <= pwdata[23:0];
                dpwp_pkg::REG_CENTER_X:    cfg_reg.center_x    <= pwdata[15:0];
                dpwp_pkg::REG_CENTER_Y:    cfg_reg.center_y    <= pwdata[15:0];
                dpwp_pkg::REG_POSE_ROW_X:  cfg_reg.pose_x      <= pwdata;
                dpwp_pkg::REG_POSE_ROW_Y:  cfg_reg.pose_y      <= pwdata;
                dpwp_pkg::REG_POSE_ROW_Z:  cfg_reg.pose_z      <= pwdata;
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (idx)
            dpwp_pkg::REG_INV_FOCAL_X: prdata = {40'd0, cfg_reg.inv_focal_x};
            dpwp_pkg::REG_INV_FOCAL_Y: prdata = {40'd0, cfg_reg.inv_focal_y};
            dpwp_pkg::REG_CENTER_X:    prdata = {48'd0, cfg_reg.center_x};
            dpwp_pkg::REG_CENTER_Y:    prdata = {48'd0, cfg_reg.center_y};
            dpwp_pkg::REG_POSE_ROW_X:  prdata = cfg_reg.pose_x;
            dpwp_pkg::REG_POSE_ROW_Y:  prdata = cfg_reg.pose_y;
            dpwp_pkg::REG_POSE_ROW_Z:  prdata = cfg_reg.pose_z;
            default:                   prdata = 64'd0;
        endcase
    end

endmodule

// File: design/depth_pixel_to_world_point_core.sv
// Depth pixel to world point: takes one pixel a cycle and, for pixels on the STEP grid with
// depth at least MIN_DEPTH, emits one world point in millimetres with its colour. A kept
// pixel passes the queue, five pipeline stages (offset, times depth, times focal reciprocal,
// rounding, rotation products) and the output register, which takes the final sum;
// throughput is one item per cycle, held back only when the output stalls and
// the two-entry queue fills. Registers are 64-bit APB words at byte address 8*index.
module depth_pixel_to_world_point_core #(
    parameter int STEP       = 3,
    parameter int MIN_DEPTH  = 10,
    parameter int COORD_BITS = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // pixel_row, pixel_col, depth_mm, blue, green, red
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // world_x, world_y, world_z, out_blue, out_green, out_red
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    dpwp_pkg::cfg_t cfg;
    dpwp_pkg::pix_t in_pix, q_pix;
    dpwp_pkg::pt_t  o_pt;
    logic           q_valid, q_ready;

    assign pready = 1'b1;
    assign in_pix = '{row: s_axis_tdata[11:0], col: s_axis_tdata[23:12],
                      depth: s_axis_tdata[39:24], blue: s_axis_tdata[47:40],
                      green: s_axis_tdata[55:48], red: s_axis_tdata[63:56]};
    assign m_axis_tdata = o_pt;

    // configuration registers
    dpwp_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
    );

    // filter and queue
    dpwp_front #(.STEP(STEP), .MIN_DEPTH(MIN_DEPTH), .COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_pix(in_pix),
        .in_ready(s_axis_tready), .q_valid(q_valid), .q_pix(q_pix), .q_ready(q_ready)
    );

    // projection and transform pipeline
    dpwp_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_pix(q_pix),
        .q_ready(q_ready), .o_valid(m_axis_tvalid), .o_pt(o_pt), .o_ready(m_axis_tready)
    );

endmodule

// File: design/dpwp_checker.sv
module dpwp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic         pready
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // input never stalls while the output flows
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready && $past(m_axis_tready) |-> s_axis_tready)
        else $error("input stalled with output free");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind depth_pixel_to_world_point_core dpwp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .pready(pready)
);
